### src/qte_pkg.sv
`default_nettype none
package qte_pkg;

	// widths of the datapath
	localparam int RAW_W = 35;
	localparam int DEN_W = 33;
	localparam int REM_W = 34;
	localparam int QUO_W = 30;
	localparam int RAD_W = 62;
	localparam int XY_W = 62;
	localparam int ANG_W = 35;
	localparam int ACC_FRAC = 24;
	localparam int TAB_LEN = 24;

	// angle limits in 2^-24 degree
	localparam logic signed [ANG_W-1:0] LIM = 35'sd3019898880;
	localparam logic signed [ANG_W-1:0] DEG90 = 35'sd1509949440;

	// one beat of a vectoring cordic lane
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic fixed;
	} cordic_t;

	// atan(2^-i) in 2^-24 degree
	function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
		logic signed [ANG_W-1:0] a;
		case (idx)
			5'd0: a = 35'sd754974720;
			5'd1: a = 35'sd445687602;
			5'd2: a = 35'sd235489088;
			5'd3: a = 35'sd119537938;
			5'd4: a = 35'sd60000934;
			5'd5: a = 35'sd30029717;
			5'd6: a = 35'sd15018523;
			5'd7: a = 35'sd7509720;
			5'd8: a = 35'sd3754917;
			5'd9: a = 35'sd1877466;
			5'd10: a = 35'sd938734;
			5'd11: a = 35'sd469367;
			5'd12: a = 35'sd234683;
			5'd13: a = 35'sd117341;
			5'd14: a = 35'sd58671;
			5'd15: a = 35'sd29335;
			5'd16: a = 35'sd14668;
			5'd17: a = 35'sd7334;
			5'd18: a = 35'sd3667;
			5'd19: a = 35'sd1833;
			5'd20: a = 35'sd917;
			5'd21: a = 35'sd458;
			5'd22: a = 35'sd229;
			5'd23: a = 35'sd115;
			default: a = '0;
		endcase
		return a;
	endfunction

	// quadrant fold and axis cases ahead of the cordic row
	function automatic cordic_t cordic_prep(input logic signed [RAW_W-1:0] y,
		input logic signed [RAW_W-1:0] x);
		cordic_t c;
		logic signed [RAW_W-1:0] xa;
		logic signed [RAW_W-1:0] ya;
		c.fixed = 1'b0;
		c.z = '0;
		xa = x;
		ya = y;
		if (y == 0) begin
			c.fixed = 1'b1;
			c.z = (x < 0) ? LIM : '0;
		end else if (x == 0) begin
			c.fixed = 1'b1;
			c.z = (y > 0) ? DEG90 : -DEG90;
		end else if (x < 0) begin
			xa = -x;
			ya = -y;
			c.z = (ya < 0) ? LIM : -LIM;
		end
		c.x = {{(XY_W-RAW_W-ACC_FRAC){xa[RAW_W-1]}}, xa, {ACC_FRAC{1'b0}}};
		c.y = {{(XY_W-RAW_W-ACC_FRAC){ya[RAW_W-1]}}, ya, {ACC_FRAC{1'b0}}};
		return c;
	endfunction

endpackage
`default_nettype wire

### src/qte_div_cell.sv
`default_nettype none
module qte_div_cell (
	input wire logic clk,
	input wire logic [qte_pkg::REM_W-1:0] rem_i,
	input wire logic [qte_pkg::DEN_W-1:0] den_i,
	input wire logic [qte_pkg::QUO_W-1:0] quo_i,
	output logic [qte_pkg::REM_W-1:0] rem_o,
	output logic [qte_pkg::DEN_W-1:0] den_o,
	output logic [qte_pkg::QUO_W-1:0] quo_o
);

	logic [qte_pkg::REM_W:0] rem2;
	logic [qte_pkg::REM_W:0] diff;
	logic ge;

	// one quotient bit: shift, compare, subtract
	always_comb begin
		rem2 = {rem_i, 1'b0};
		diff = rem2 - (qte_pkg::REM_W+1)'(den_i);
		ge = rem2 >= (qte_pkg::REM_W+1)'(den_i);
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[qte_pkg::REM_W-1:0] : rem2[qte_pkg::REM_W-1:0];
		den_o <= den_i;
		quo_o <= {quo_i[qte_pkg::QUO_W-2:0], ge};
	end

endmodule
`default_nettype wire

### src/qte_sqrt_cell.sv
`default_nettype none
module qte_sqrt_cell #(
	parameter int K = 0
) (
	input wire logic clk,
	input wire logic [qte_pkg::RAD_W-1:0] rad_i,
	input wire logic [qte_pkg::RAD_W-1:0] root_i,
	output logic [qte_pkg::RAD_W-1:0] rad_o,
	output logic [qte_pkg::RAD_W-1:0] root_o
);

	localparam logic [qte_pkg::RAD_W-1:0] BIT = qte_pkg::RAD_W'(1) << (2 * K);

	logic [qte_pkg::RAD_W-1:0] trial;
	logic take;

	// one root bit of the digit recurrence
	always_comb begin
		trial = root_i + BIT;
		take = rad_i >= trial;
	end

	always_ff @(posedge clk) begin
		rad_o <= take ? rad_i - trial : rad_i;
		root_o <= take ? (root_i >> 1) + BIT : (root_i >> 1);
	end

endmodule
`default_nettype wire

### src/qte_cordic_cell.sv
`default_nettype none
module qte_cordic_cell #(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire qte_pkg::cordic_t d_i,
	output qte_pkg::cordic_t d_o
);

	localparam logic signed [qte_pkg::ANG_W-1:0] ANG = qte_pkg::atan_deg(5'(STAGE));

	logic signed [qte_pkg::XY_W-1:0] dx;
	logic signed [qte_pkg::XY_W-1:0] dy;
	qte_pkg::cordic_t nxt;

	// one micro-rotation toward the x axis
	always_comb begin
		dx = d_i.y >>> STAGE;
		dy = d_i.x >>> STAGE;
		nxt = d_i;
		if (!d_i.fixed) begin
			if (d_i.y >= 0) begin
				nxt.x = d_i.x + dx;
				nxt.y = d_i.y - dy;
				nxt.z = d_i.z + ANG;
			end else begin
				nxt.x = d_i.x - dx;
				nxt.y = d_i.y + dy;
				nxt.z = d_i.z - ANG;
			end
		end
	end

	always_ff @(posedge clk) begin
		d_o <= nxt;
	end

endmodule
`default_nettype wire

### src/quaternion_to_euler_heading.sv
// Quaternion to yaw, pitch, roll and compass heading, ZYX convention.
// Input channel: a beat is taken at each rising edge with start high and busy
// low. busy is held low, so a new quaternion can enter on every clock.
// Result channel: done is high for exactly one cycle with yaw_angle,
// pitch_angle, roll_angle and heading_angle valid in that cycle; the
// receiver has no way to stall and must take the beat then.
// The cordic rows have N = min(CORDIC_STAGES, 24) cells. Throughput: one
// beat per cycle. The latency is set by the pitch path: a 30-cell restoring
// divider row, a squaring stage, a 31-cell square root row and the N-cell
// cordic row. Yaw and roll wait in a delay line and run through their own
// cordic rows beside pitch.
// Angles are signed with ANGLE_FRAC_BITS fraction bits of a degree.
// Reset clears the valid line only; beats in flight at reset are dropped and
// no strobe appears until a new beat has gone through.
`default_nettype none
module quaternion_to_euler_heading #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [15:0] quat_real,
	input wire logic signed [15:0] quat_i,
	input wire logic signed [15:0] quat_j,
	input wire logic signed [15:0] quat_k,
	output logic done,
	output logic signed [15:0] yaw_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] roll_angle,
	output logic signed [16:0] heading_angle
);

	localparam int N = (CORDIC_STAGES > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : CORDIC_STAGES;
	localparam int SH = qte_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int LEN_V = 68 + N;
	localparam int LEN_F = 64 + N;
	localparam int LEN_R = 64;
	localparam int LEN_Q = 33;
	localparam int RW = qte_pkg::RAW_W;
	localparam logic signed [RW-1:0] U90 = 35'sd90 <<< ANGLE_FRAC_BITS;
	localparam logic signed [RW-1:0] U180 = 35'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic signed [RW-1:0] U270 = 35'sd270 <<< ANGLE_FRAC_BITS;
	localparam logic signed [RW-1:0] HALF = 35'sd1 <<< (SH - 1);

	typedef struct packed {
		logic zero;
		logic sat;
		logic neg;
	} pfl_t;

	// valid line
	logic [LEN_V-1:0] vld_q;
	logic done_q;

	// input and product stages
	logic signed [15:0] qr_s1, qi_s1, qj_s1, qk_s1;
	logic signed [31:0] p_rr_s2, p_ii_s2, p_jj_s2, p_kk_s2;
	logic signed [31:0] p_ij_s2, p_kr_s2, p_jk_s2, p_ir_s2, p_jr_s2, p_ik_s2;
	logic signed [RW-1:0] yaw_y_s3, yaw_x_s3, roll_y_s3, roll_x_s3, num_s3;
	logic [qte_pkg::DEN_W-1:0] den_s3;

	// pitch path
	logic signed [RW-1:0] mag_full;
	logic [qte_pkg::REM_W-1:0] rem_c [31];
	logic [qte_pkg::DEN_W-1:0] den_c [31];
	logic [qte_pkg::QUO_W-1:0] quo_c [31];
	pfl_t fl_s4;
	logic [2*qte_pkg::QUO_W-1:0] sq_s35;
	logic [qte_pkg::RAD_W-1:0] rad_c [32];
	logic [qte_pkg::RAD_W-1:0] root_c [32];
	logic [qte_pkg::QUO_W-1:0] quo_dl [LEN_Q];
	pfl_t pfl_dl [LEN_F];
	logic signed [RW-1:0] s_sgn;
	pfl_t fl_pre;
	pfl_t fl_fin;

	// yaw and roll wait line
	logic signed [RW-1:0] yy_dl [LEN_R];
	logic signed [RW-1:0] yx_dl [LEN_R];
	logic signed [RW-1:0] ry_dl [LEN_R];
	logic signed [RW-1:0] rx_dl [LEN_R];

	// cordic rows
	qte_pkg::cordic_t ch_y [N+1];
	qte_pkg::cordic_t ch_r [N+1];
	qte_pkg::cordic_t ch_p [N+1];

	// final stage
	logic signed [RW-1:0] yaw_u, roll_u, pitch_u, head_u;
	logic signed [15:0] yaw_q;
	logic signed [14:0] pitch_q;
	logic signed [15:0] roll_q;
	logic signed [16:0] head_q;

	function automatic logic signed [RW-1:0] to_unit(input logic signed [RW-1:0] z);
		logic signed [RW-1:0] zc;
		logic signed [RW-1:0] zr;
		zc = z;
		if (z > qte_pkg::LIM) begin
			zc = qte_pkg::LIM;
		end else if (z < -qte_pkg::LIM) begin
			zc = -qte_pkg::LIM;
		end
		zr = zc + HALF;
		return zr >>> SH;
	endfunction

	assign busy = 1'b0;

	// valid bits march beside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[LEN_V-2:0], start & ~busy};
			done_q <= vld_q[LEN_V-1];
		end
	end

	// capture, products, sums
	always_ff @(posedge clk) begin
		qr_s1 <= quat_real;
		qi_s1 <= quat_i;
		qj_s1 <= quat_j;
		qk_s1 <= quat_k;
		p_rr_s2 <= qr_s1 * qr_s1;
		p_ii_s2 <= qi_s1 * qi_s1;
		p_jj_s2 <= qj_s1 * qj_s1;
		p_kk_s2 <= qk_s1 * qk_s1;
		p_ij_s2 <= qi_s1 * qj_s1;
		p_kr_s2 <= qk_s1 * qr_s1;
		p_jk_s2 <= qj_s1 * qk_s1;
		p_ir_s2 <= qi_s1 * qr_s1;
		p_jr_s2 <= qj_s1 * qr_s1;
		p_ik_s2 <= qi_s1 * qk_s1;
		yaw_y_s3 <= (RW'(p_ij_s2) + RW'(p_kr_s2)) <<< 1;
		yaw_x_s3 <= RW'(p_ii_s2) - RW'(p_jj_s2) - RW'(p_kk_s2) + RW'(p_rr_s2);
		roll_y_s3 <= (RW'(p_jk_s2) + RW'(p_ir_s2)) <<< 1;
		roll_x_s3 <= RW'(p_kk_s2) + RW'(p_rr_s2) - RW'(p_ii_s2) - RW'(p_jj_s2);
		num_s3 <= (RW'(p_jr_s2) - RW'(p_ik_s2)) <<< 1;
		den_s3 <= qte_pkg::DEN_W'($unsigned(p_ii_s2)) + qte_pkg::DEN_W'($unsigned(p_jj_s2))
			+ qte_pkg::DEN_W'($unsigned(p_kk_s2)) + qte_pkg::DEN_W'($unsigned(p_rr_s2));
	end

	// asin argument: magnitude, saturation and zero cases
	assign mag_full = (num_s3 < 0) ? -num_s3 : num_s3;

	always_ff @(posedge clk) begin
		rem_c[0] <= mag_full[qte_pkg::REM_W-1:0];
		den_c[0] <= den_s3;
		quo_c[0] <= '0;
		fl_s4.zero <= (den_s3 == '0) || (num_s3 == '0);
		fl_s4.sat <= (den_s3 != '0) && (num_s3 != '0)
			&& (mag_full[qte_pkg::REM_W-1:0] >= qte_pkg::REM_W'(den_s3));
		fl_s4.neg <= num_s3 < 0;
	end

	// divider row, one quotient bit per cell
	for (genvar g = 0; g < 30; g++) begin : g_div
		qte_div_cell u_div (
			.clk(clk),
			.rem_i(rem_c[g]),
			.den_i(den_c[g]),
			.quo_i(quo_c[g]),
			.rem_o(rem_c[g+1]),
			.den_o(den_c[g+1]),
			.quo_o(quo_c[g+1])
		);
	end

	// cosine partner radicand: 1 - s^2 in Q60
	always_ff @(posedge clk) begin
		sq_s35 <= quo_c[30] * quo_c[30];
		rad_c[0] <= (qte_pkg::RAD_W'(1) << 60) - qte_pkg::RAD_W'(sq_s35);
		root_c[0] <= '0;
	end

	// square root row, one root bit per cell
	for (genvar g = 0; g < 31; g++) begin : g_sqrt
		qte_sqrt_cell #(.K(30 - g)) u_sqrt (
			.clk(clk),
			.rad_i(rad_c[g]),
			.root_i(root_c[g]),
			.rad_o(rad_c[g+1]),
			.root_o(root_c[g+1])
		);
	end

	// sine term waits beside the square root row
	always_ff @(posedge clk) begin
		quo_dl[0] <= quo_c[30];
		for (int i = 1; i < LEN_Q; i++) begin
			quo_dl[i] <= quo_dl[i-1];
		end
	end

	// pitch flags and yaw/roll terms wait for the pitch path
	always_ff @(posedge clk) begin
		pfl_dl[0] <= fl_s4;
		for (int i = 1; i < LEN_F; i++) begin
			pfl_dl[i] <= pfl_dl[i-1];
		end
		yy_dl[0] <= yaw_y_s3;
		yx_dl[0] <= yaw_x_s3;
		ry_dl[0] <= roll_y_s3;
		rx_dl[0] <= roll_x_s3;
		for (int i = 1; i < LEN_R; i++) begin
			yy_dl[i] <= yy_dl[i-1];
			yx_dl[i] <= yx_dl[i-1];
			ry_dl[i] <= ry_dl[i-1];
			rx_dl[i] <= rx_dl[i-1];
		end
	end

	// cordic entry for all three angles
	assign fl_pre = pfl_dl[62];
	assign s_sgn = fl_pre.neg ? -RW'(quo_dl[LEN_Q-1]) : RW'(quo_dl[LEN_Q-1]);

	always_ff @(posedge clk) begin
		ch_y[0] <= qte_pkg::cordic_prep(yy_dl[LEN_R-1], yx_dl[LEN_R-1]);
		ch_r[0] <= qte_pkg::cordic_prep(ry_dl[LEN_R-1], rx_dl[LEN_R-1]);
		ch_p[0] <= qte_pkg::cordic_prep(s_sgn, RW'(root_c[31]));
	end

	// cordic rows
	for (genvar g = 0; g < N; g++) begin : g_cordic
		qte_cordic_cell #(.STAGE(g)) u_yaw (.clk(clk), .d_i(ch_y[g]), .d_o(ch_y[g+1]));
		qte_cordic_cell #(.STAGE(g)) u_roll (.clk(clk), .d_i(ch_r[g]), .d_o(ch_r[g+1]));
		qte_cordic_cell #(.STAGE(g)) u_pitch (.clk(clk), .d_i(ch_p[g]), .d_o(ch_p[g+1]));
	end

	// clamp, round, pitch overrides and heading rule
	assign fl_fin = pfl_dl[LEN_F-1];

	always_comb begin
		yaw_u = to_unit(ch_y[N].z);
		roll_u = to_unit(ch_r[N].z);
		if (fl_fin.zero) begin
			pitch_u = '0;
		end else if (fl_fin.sat) begin
			pitch_u = fl_fin.neg ? -U90 : U90;
		end else begin
			pitch_u = to_unit(ch_p[N].z);
		end
		if (yaw_u > -U90 && yaw_u < U180) begin
			head_u = U90 - yaw_u;
		end else begin
			head_u = -(yaw_u + U270);
		end
	end

	always_ff @(posedge clk) begin
		yaw_q <= yaw_u[15:0];
		pitch_q <= pitch_u[14:0];
		roll_q <= roll_u[15:0];
		head_q <= head_u[16:0];
	end

	assign done = done_q;
	assign yaw_angle = yaw_q;
	assign pitch_angle = pitch_q;
	assign roll_angle = roll_q;
	assign heading_angle = head_q;

endmodule
`default_nettype wire

### src/qte_check.sv
`default_nettype none
module qte_check #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [15:0] quat_real,
	input wire logic [15:0] quat_i,
	input wire logic [15:0] quat_j,
	input wire logic [15:0] quat_k,
	input wire logic done,
	input wire logic [15:0] yaw_angle,
	input wire logic [14:0] pitch_angle,
	input wire logic [15:0] roll_angle,
	input wire logic [16:0] heading_angle
);

	localparam int N = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int LAT = 69 + N;
	localparam logic [15:0] H90 = 16'(90 << ANGLE_FRAC_BITS);
	localparam logic [15:0] H270 = 16'(270 << ANGLE_FRAC_BITS);

	logic [15:0] head_a;
	logic [15:0] head_b;

	// heading candidates, low bits only
	assign head_a = H90 - yaw_angle;
	assign head_b = 16'(16'd0 - (yaw_angle + H270));

	// every accepted beat gives a strobe after the fixed latency
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing");

	// no strobe without a beat taken the latency before
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without accepted beat");

	// heading follows one of the two quadrant branches of yaw
	a_heading: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading_angle[15:0] == head_a || heading_angle[15:0] == head_b))
		else $error("heading inconsistent with yaw");

	// all-zero quaternion gives zero angles and a heading of 90
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && quat_real == 16'd0 && quat_i == 16'd0 && quat_j == 16'd0
			&& quat_k == 16'd0) |-> ##LAT (done && yaw_angle == 16'd0
			&& pitch_angle == 15'd0 && roll_angle == 16'd0
			&& heading_angle[15:0] == H90))
		else $error("zero quaternion result wrong");

endmodule

bind quaternion_to_euler_heading qte_check #(
	.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
	.CORDIC_STAGES(CORDIC_STAGES)
) u_qte_check (.*);
`default_nettype wire
